// ===== rtl/rmwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmwm_pkg
// shared types and constants for the range max of window minimums core
// ----------------------------------------------------------------------------
package rmwm_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = 11;
    localparam int HEIGHT_W      = 30;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [HEIGHT_W-1:0] height;
    } t_entry;

endpackage

// ===== rtl/range_max_window_min_core.sv =====
// ----------------------------------------------------------------------------
// range_max_window_min_core
// largest window minimum over a range of stored heights
// ----------------------------------------------------------------------------
// a load beat is taken and gives no result
// a query scans each position in range, dropping queue entries no lower than the new height
// from the back and expired entries from the front, then gives the result beat
// an empty range, a zero window or a window that does not fit skips the scan, found low
// input stalls while a query runs or its result waits on a stalled output
// synchronous active-low reset clears control, height memory is unset until written
module range_max_window_min_core
    import rmwm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [POS_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [POS_W-1:0]    i_position,
    input  logic [HEIGHT_W-1:0] i_height,
    input  logic [POS_W-1:0]    i_query_left,
    input  logic [POS_W-1:0]    i_query_right,
    input  logic [POS_W-1:0]    i_window_width,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [HEIGHT_W-1:0] o_best_height,
    output logic                o_found
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_QWAIT = 3'd3;
    localparam logic [2:0] ST_FRONT = 3'd4;
    localparam logic [2:0] ST_FWAIT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [POS_W-1:0] MAX_N = POS_W'(MAX_POSITIONS);

    logic [HEIGHT_W-1:0] height_mem [MAX_POSITIONS];
    t_entry              queue_mem  [MAX_POSITIONS];

    logic [2:0]          r_state;
    logic [POS_W-1:0]    r_fence_length;
    logic [POS_W-1:0]    r_i, r_lo, r_hi, r_w;
    logic [POS_W-1:0]    r_head, r_tail;
    t_entry              r_front, r_back;
    logic [HEIGHT_W-1:0] r_top, r_hrd;
    t_entry              r_qrd;
    logic                r_ok;
    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_best;
    logic                r_found;

    logic [POS_W-1:0]    n_len, n_lo, n_hi;
    logic                in_acc, q_re, q_we, h_re;
    logic [ADDR_W-1:0]   q_raddr;
    logic                pop_back, expire;

    assign in_acc = i_in_valid && !o_in_stall;
    assign n_len  = (r_fence_length > MAX_N) ? MAX_N : r_fence_length;
    assign n_lo   = (i_query_left == '0) ? POS_W'(1) : i_query_left;
    assign n_hi   = (i_query_right > n_len) ? n_len : i_query_right;

    assign pop_back = (r_tail > r_head) && (r_back.height >= r_hrd);
    assign expire   = ({1'b0, r_front.pos} + {1'b0, r_w}) <= {1'b0, r_i};

    always_comb begin
        q_re    = 1'b0;
        q_raddr = '0;
        q_we    = 1'b0;
        h_re    = (r_state == ST_READ);
        case (r_state)
            ST_POP: begin
                if (pop_back) begin
                    q_re    = (r_tail - POS_W'(1)) > r_head;
                    q_raddr = ADDR_W'(r_tail - POS_W'(2));
                end else begin
                    q_we = 1'b1;
                end
            end
            ST_FRONT: begin
                q_re    = expire;
                q_raddr = ADDR_W'(r_head + POS_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_LOAD && i_position != '0 && i_position <= n_len) begin
            height_mem[ADDR_W'(i_position - POS_W'(1))] <= i_height;
        end
        if (h_re) begin
            r_hrd <= height_mem[ADDR_W'(r_i - POS_W'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[ADDR_W'(r_tail)] <= '{pos: r_i, height: r_hrd};
        end
        if (q_re) begin
            r_qrd <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_fence_length <= POS_W'(1);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fence_length <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_operation == OP_QUERY) begin
                        r_lo   <= n_lo;
                        r_hi   <= n_hi;
                        r_w    <= i_window_width;
                        r_i    <= n_lo;
                        r_head <= '0;
                        r_tail <= '0;
                        r_top  <= '0;
                        if (i_window_width == '0 || n_lo > n_hi ||
                            {1'b0, i_window_width} > ({1'b0, n_hi} - {1'b0, n_lo} + 12'd1)) begin
                            r_ok    <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_ok    <= 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_POP;
                end
                ST_POP: begin
                    if (pop_back) begin
                        r_tail  <= r_tail - POS_W'(1);
                        r_state <= q_re ? ST_QWAIT : ST_POP;
                    end else begin
                        r_back <= '{pos: r_i, height: r_hrd};
                        if (r_tail == r_head) begin
                            r_front <= '{pos: r_i, height: r_hrd};
                        end
                        r_tail  <= r_tail + POS_W'(1);
                        r_state <= ST_FRONT;
                    end
                end
                ST_QWAIT: begin
                    r_back  <= r_qrd;
                    r_state <= ST_POP;
                end
                ST_FRONT: begin
                    if (expire) begin
                        r_head  <= r_head + POS_W'(1);
                        r_state <= ST_FWAIT;
                    end else begin
                        if (({1'b0, r_i} + 12'd1) >= ({1'b0, r_lo} + {1'b0, r_w}) &&
                            r_front.height > r_top) begin
                            r_top <= r_front.height;
                        end
                        if (r_i == r_hi) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_i     <= r_i + POS_W'(1);
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_FWAIT: begin
                    r_front <= r_qrd;
                    r_state <= ST_FRONT;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_best      <= r_ok ? r_top : '0;
                        r_found     <= r_ok;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_best_height = r_best;
    assign o_found       = r_found;

endmodule

// ===== rtl/rmwm_checker.sv =====
// ----------------------------------------------------------------------------
// rmwm_checker
// port-level checks for the range max of window minimums core
// ----------------------------------------------------------------------------
module rmwm_checker
    import rmwm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_operation,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [HEIGHT_W-1:0] o_best_height,
    input logic                o_found
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_best_height) && $stable(o_found))
        else $error("stalled result beat changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_best_height == '0)
        else $error("missing window with nonzero height");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == OP_QUERY |=> o_in_stall)
        else $error("query beat did not occupy the core");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat after reset");

endmodule

bind range_max_window_min_core rmwm_checker u_rmwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_best_height (o_best_height),
    .o_found       (o_found)
);
